FILE: rtl/dkt_pkg.sv
// Shared types and constants for the dual-key time map table.
// Request and result structs, request and status codes, controller states.
// No dependencies.
`timescale 1ns / 1ps

package dkt_pkg;

	localparam int CAPACITY = 1024;
	localparam int MAX_LIST = 64;
	// ring of twice the capacity holds one extra pair before eviction
	localparam int ADDR_W   = $clog2(2 * CAPACITY);
	localparam int FILL_W   = 11;
	localparam int CNT_W    = 7;
	localparam int PAIR_W   = 128;

	localparam logic [10:0] KEEP_RESET = 11'd1000;
	localparam logic [10:0] CAP_FILL   = 11'(CAPACITY);
	localparam logic [6:0]  MAX_LIST_C = 7'(MAX_LIST);

	localparam logic [2:0] REQ_INSERT  = 3'd0;
	localparam logic [2:0] REQ_FLOOR_L = 3'd1;
	localparam logic [2:0] REQ_FLOOR_R = 3'd2;
	localparam logic [2:0] REQ_LIST_L  = 3'd3;
	localparam logic [2:0] REQ_LIST_R  = 3'd4;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_DUP_REAL = 2'd1;
	localparam logic [1:0] ST_DUP_LOG = 2'd2;
	localparam logic [1:0] ST_EMPTY   = 2'd3;

	typedef struct packed {
		logic [2:0]  req_type;
		logic [63:0] logical_us;
		logic [63:0] real_us;
		logic        inclusive;
		logic [6:0]  max_count;
	} req_t;

	typedef struct packed {
		logic [63:0] out_logical_us;
		logic [63:0] out_real_us;
		logic [1:0]  status;
		logic        last;
	} rsp_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SRCH_RD,
		S_SRCH_CMP,
		S_DISPATCH,
		S_SH_RD,
		S_SH_WR,
		S_INS_WR,
		S_RD_ENT,
		S_EMIT_ENT,
		S_EMIT_CONST
	} state_t;

endpackage

FILE: rtl/dual_key_time_map_table.sv
// Dual-key time map table: top level with controller and two pair stores.
// Depends on dkt_pkg and dkt_ram.
`timescale 1ns / 1ps
//
// Usage:
//   Input channel (in_valid/in_stall/in_data) takes one request: insert,
//   floor by logical or real time, or list from logical or real time.
//   Output channel (out_valid/out_stall/out_data) returns the results; the
//   final result of each request has last set. A list returns up to 64 pairs.
//   cfg_valid/cfg_ready/cfg_data write keep_limit; write it only while idle.
// Sequencing:
//   One request at a time. Both stores are binary searched together; each
//   step reads the RAM in S_SRCH_RD and compares the read pair in S_SRCH_CMP.
//   An insert then moves each pair above the insert point up one slot, with
//   a read in S_SH_RD and a write in S_SH_WR for each move.
//   A floor reads one pair; a list reads each pair in S_RD_ENT, emits it in
//   S_EMIT_ENT. Eviction of the smallest keys is a ring head advance in S_INS_WR.
// Reset clears both fill counts and sets keep_limit to 1000; store contents
// are left as they are. A stalled output holds its result and the controller
// waits on it before loading the next.

module dual_key_time_map_table (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_stall,
	input  dkt_pkg::req_t in_data,
	output logic         out_valid,
	input  logic         out_stall,
	output dkt_pkg::rsp_t out_data,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [10:0]  cfg_data
);

	localparam int AW = dkt_pkg::ADDR_W;
	localparam int FW = dkt_pkg::FILL_W;
	localparam int CW = dkt_pkg::CNT_W;
	localparam int PW = dkt_pkg::PAIR_W;

	dkt_pkg::state_t state_q, state_d;
	dkt_pkg::req_t   req_q;
	dkt_pkg::rsp_t   res_q, res_d, out_q, out_nxt;
	logic            out_valid_q, out_load;

	logic [10:0]   keep_q;
	logic [AW-1:0] head_l_q, head_r_q;
	logic [FW-1:0] fill_l_q, fill_r_q;
	logic [FW-1:0] lo_l_q, hi_l_q, lo_r_q, hi_r_q;
	logic [FW-1:0] mid_l, mid_r;
	logic          eq_l_q, eq_r_q;
	logic [FW-1:0] sh_l_q, sh_r_q, rem_l_q, rem_r_q;
	logic          tab_q;
	logic [FW-1:0] idx_q;
	logic [CW-1:0] cnt_q;
	logic          act_l, act_r, strict;

	logic          we_l, we_r, re_l, re_r;
	logic [AW-1:0] waddr_l, waddr_r, raddr_l, raddr_r;
	logic [PW-1:0] wdata_l, wdata_r, rdata_l, rdata_r;
	logic [63:0]   key_l, key_r;
	logic          before_l, before_r;

	logic [10:0]   lim;
	logic [FW-1:0] n1_l, n1_r;
	logic [FW-1:0] p_sel, fill_sel, avail, floor_idx;
	logic          eq_sel;
	logic [CW-1:0] mc, list_n;
	logic          slot_free;
	logic [PW-1:0] ent;

	dkt_ram #(.ADDR_W(AW), .DATA_W(PW)) u_ram_l (
		.clk(clk), .we(we_l), .waddr(waddr_l), .wdata(wdata_l),
		.re(re_l), .raddr(raddr_l), .rdata(rdata_l)
	);

	dkt_ram #(.ADDR_W(AW), .DATA_W(PW)) u_ram_r (
		.clk(clk), .we(we_r), .waddr(waddr_r), .wdata(wdata_r),
		.re(re_r), .raddr(raddr_r), .rdata(rdata_r)
	);

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != dkt_pkg::S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign slot_free = !out_valid_q || !out_stall;

	assign act_l  = lo_l_q < hi_l_q;
	assign act_r  = lo_r_q < hi_r_q;
	assign mid_l  = lo_l_q + ((hi_l_q - lo_l_q) >> 1);
	assign mid_r  = lo_r_q + ((hi_r_q - lo_r_q) >> 1);
	assign strict = ((req_q.req_type == dkt_pkg::REQ_LIST_L) ||
		(req_q.req_type == dkt_pkg::REQ_LIST_R)) && !req_q.inclusive;
	assign key_l  = rdata_l[PW-1:64];
	assign key_r  = rdata_r[PW-1:64];
	assign before_l = strict ? (key_l <= req_q.logical_us) : (key_l < req_q.logical_us);
	assign before_r = strict ? (key_r <= req_q.real_us) : (key_r < req_q.real_us);

	assign lim  = (keep_q > dkt_pkg::CAP_FILL) ? dkt_pkg::CAP_FILL : keep_q;
	assign n1_l = fill_l_q + 1'b1;
	assign n1_r = fill_r_q + 1'b1;

	// floor and list operate on the table named by the request
	always_comb begin
		logic by_l;
		by_l     = (req_q.req_type == dkt_pkg::REQ_FLOOR_L) ||
			(req_q.req_type == dkt_pkg::REQ_LIST_L);
		p_sel    = by_l ? lo_l_q : lo_r_q;
		fill_sel = by_l ? fill_l_q : fill_r_q;
		eq_sel   = by_l ? eq_l_q : eq_r_q;
		avail    = fill_sel - p_sel;
		mc       = (req_q.max_count > dkt_pkg::MAX_LIST_C) ? dkt_pkg::MAX_LIST_C
			: req_q.max_count;
		list_n   = (avail > FW'(mc)) ? mc : avail[CW-1:0];
		if (fill_sel == FW'(1)) begin
			floor_idx = '0;
		end else if (eq_sel || (p_sel == '0)) begin
			floor_idx = p_sel;
		end else begin
			floor_idx = p_sel - 1'b1;
		end
	end

	assign ent = tab_q ? rdata_r : rdata_l;

	always_comb begin
		state_d  = state_q;
		res_d    = res_q;
		out_load = 1'b0;
		out_nxt  = res_q;
		re_l     = 1'b0;
		re_r     = 1'b0;
		raddr_l  = head_l_q + mid_l;
		raddr_r  = head_r_q + mid_r;
		we_l     = 1'b0;
		we_r     = 1'b0;
		waddr_l  = head_l_q + sh_l_q + 1'b1;
		waddr_r  = head_r_q + sh_r_q + 1'b1;
		wdata_l  = rdata_l;
		wdata_r  = rdata_r;

		case (state_q)
			dkt_pkg::S_IDLE: begin
				if (in_valid) begin
					state_d = dkt_pkg::S_SRCH_RD;
				end
			end
			dkt_pkg::S_SRCH_RD: begin
				if (!act_l && !act_r) begin
					state_d = dkt_pkg::S_DISPATCH;
				end else begin
					re_l    = act_l;
					re_r    = act_r;
					state_d = dkt_pkg::S_SRCH_CMP;
				end
			end
			dkt_pkg::S_SRCH_CMP: begin
				state_d = dkt_pkg::S_SRCH_RD;
			end
			dkt_pkg::S_DISPATCH: begin
				res_d.out_logical_us = req_q.logical_us;
				res_d.out_real_us    = req_q.real_us;
				res_d.status         = dkt_pkg::ST_OK;
				res_d.last           = 1'b1;
				case (req_q.req_type)
					dkt_pkg::REQ_INSERT: begin
						if (eq_r_q) begin
							res_d.status = dkt_pkg::ST_DUP_REAL;
							state_d      = dkt_pkg::S_EMIT_CONST;
						end else if (eq_l_q) begin
							res_d.status = dkt_pkg::ST_DUP_LOG;
							state_d      = dkt_pkg::S_EMIT_CONST;
						end else if ((fill_l_q != lo_l_q) || (fill_r_q != lo_r_q)) begin
							state_d = dkt_pkg::S_SH_RD;
						end else begin
							state_d = dkt_pkg::S_INS_WR;
						end
					end
					dkt_pkg::REQ_FLOOR_L, dkt_pkg::REQ_FLOOR_R: begin
						if (fill_sel == '0) begin
							if (req_q.req_type == dkt_pkg::REQ_FLOOR_L) begin
								res_d.out_real_us = req_q.logical_us;
							end else begin
								res_d.out_logical_us = req_q.real_us;
							end
							state_d = dkt_pkg::S_EMIT_CONST;
						end else begin
							state_d = dkt_pkg::S_RD_ENT;
						end
					end
					dkt_pkg::REQ_LIST_L, dkt_pkg::REQ_LIST_R: begin
						if (list_n == '0) begin
							res_d.out_logical_us = '0;
							res_d.out_real_us    = '0;
							res_d.status         = dkt_pkg::ST_EMPTY;
							state_d              = dkt_pkg::S_EMIT_CONST;
						end else begin
							state_d = dkt_pkg::S_RD_ENT;
						end
					end
					default: begin
						res_d.out_logical_us = '0;
						res_d.out_real_us    = '0;
						res_d.status         = dkt_pkg::ST_EMPTY;
						state_d              = dkt_pkg::S_EMIT_CONST;
					end
				endcase
			end
			dkt_pkg::S_SH_RD: begin
				re_l    = rem_l_q != '0;
				re_r    = rem_r_q != '0;
				raddr_l = head_l_q + sh_l_q;
				raddr_r = head_r_q + sh_r_q;
				state_d = dkt_pkg::S_SH_WR;
			end
			dkt_pkg::S_SH_WR: begin
				we_l = rem_l_q != '0;
				we_r = rem_r_q != '0;
				if ((rem_l_q > FW'(1)) || (rem_r_q > FW'(1))) begin
					state_d = dkt_pkg::S_SH_RD;
				end else begin
					state_d = dkt_pkg::S_INS_WR;
				end
			end
			dkt_pkg::S_INS_WR: begin
				we_l    = 1'b1;
				we_r    = 1'b1;
				waddr_l = head_l_q + lo_l_q;
				waddr_r = head_r_q + lo_r_q;
				wdata_l = {req_q.logical_us, req_q.real_us};
				wdata_r = {req_q.real_us, req_q.logical_us};
				state_d = dkt_pkg::S_EMIT_CONST;
			end
			dkt_pkg::S_RD_ENT: begin
				re_l    = !tab_q;
				re_r    = tab_q;
				raddr_l = head_l_q + idx_q;
				raddr_r = head_r_q + idx_q;
				state_d = dkt_pkg::S_EMIT_ENT;
			end
			dkt_pkg::S_EMIT_ENT: begin
				if (tab_q) begin
					out_nxt.out_logical_us = ent[63:0];
					out_nxt.out_real_us    = ent[PW-1:64];
				end else begin
					out_nxt.out_logical_us = ent[PW-1:64];
					out_nxt.out_real_us    = ent[63:0];
				end
				out_nxt.status = dkt_pkg::ST_OK;
				out_nxt.last   = cnt_q == CW'(1);
				if (slot_free) begin
					out_load = 1'b1;
					state_d  = (cnt_q == CW'(1)) ? dkt_pkg::S_IDLE : dkt_pkg::S_RD_ENT;
				end
			end
			dkt_pkg::S_EMIT_CONST: begin
				if (slot_free) begin
					out_load = 1'b1;
					state_d  = dkt_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = dkt_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dkt_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_q      <= dkt_pkg::KEEP_RESET;
			fill_l_q    <= '0;
			fill_r_q    <= '0;
			head_l_q    <= '0;
			head_r_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				keep_q <= cfg_data;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			// evict smallest keys by advancing the ring head
			if (state_q == dkt_pkg::S_INS_WR) begin
				if (n1_l > lim) begin
					head_l_q <= head_l_q + AW'(n1_l - lim);
					fill_l_q <= lim;
				end else begin
					fill_l_q <= n1_l;
				end
				if (n1_r > lim) begin
					head_r_q <= head_r_q + AW'(n1_r - lim);
					fill_r_q <= lim;
				end else begin
					fill_r_q <= n1_r;
				end
			end
		end
	end

	// payload and datapath registers
	always_ff @(posedge clk) begin
		res_q <= res_d;
		if (out_load) begin
			out_q <= out_nxt;
		end
		case (state_q)
			dkt_pkg::S_IDLE: begin
				if (in_valid) begin
					req_q  <= in_data;
					lo_l_q <= '0;
					lo_r_q <= '0;
					hi_l_q <= fill_l_q;
					hi_r_q <= fill_r_q;
					eq_l_q <= 1'b0;
					eq_r_q <= 1'b0;
				end
			end
			dkt_pkg::S_SRCH_CMP: begin
				if (act_l) begin
					if (before_l) begin
						lo_l_q <= mid_l + 1'b1;
					end else begin
						hi_l_q <= mid_l;
						eq_l_q <= key_l == req_q.logical_us;
					end
				end
				if (act_r) begin
					if (before_r) begin
						lo_r_q <= mid_r + 1'b1;
					end else begin
						hi_r_q <= mid_r;
						eq_r_q <= key_r == req_q.real_us;
					end
				end
			end
			dkt_pkg::S_DISPATCH: begin
				sh_l_q  <= fill_l_q - 1'b1;
				sh_r_q  <= fill_r_q - 1'b1;
				rem_l_q <= fill_l_q - lo_l_q;
				rem_r_q <= fill_r_q - lo_r_q;
				tab_q   <= (req_q.req_type == dkt_pkg::REQ_FLOOR_R) ||
					(req_q.req_type == dkt_pkg::REQ_LIST_R);
				if ((req_q.req_type == dkt_pkg::REQ_FLOOR_L) ||
					(req_q.req_type == dkt_pkg::REQ_FLOOR_R)) begin
					idx_q <= floor_idx;
					cnt_q <= CW'(1);
				end else begin
					idx_q <= p_sel;
					cnt_q <= list_n;
				end
			end
			dkt_pkg::S_SH_WR: begin
				if (rem_l_q != '0) begin
					sh_l_q  <= sh_l_q - 1'b1;
					rem_l_q <= rem_l_q - 1'b1;
				end
				if (rem_r_q != '0) begin
					sh_r_q  <= sh_r_q - 1'b1;
					rem_r_q <= rem_r_q - 1'b1;
				end
			end
			dkt_pkg::S_EMIT_ENT: begin
				if (slot_free) begin
					idx_q <= idx_q + 1'b1;
					cnt_q <= cnt_q - 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

FILE: rtl/dkt_ram.sv
// Simple dual-port RAM: one write port, one read port, registered read data.
// Generic; used for both pair stores. No package dependency.
`timescale 1ns / 1ps

module dkt_ram #(
	parameter int ADDR_W = 11,
	parameter int DATA_W = 128
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem_q [2**ADDR_W];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// hold read data until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
